// File: hdl/shist_pkg.sv
// Shared types and constants of the sample histogram block.
// No dependencies; compile before every other file of the block.
package shist_pkg;

    localparam int MAX_SAMPLE_BITS = 16;
    localparam int COUNT_BITS      = 32;
    localparam int NARROW_BITS     = 8;
    localparam int ADDR_W          = MAX_SAMPLE_BITS;
    localparam int VALUE_W         = 16;
    localparam int OUT_COUNT_W     = 32;
    localparam int MODE_W          = 2;
    localparam int STATUS_W        = 2;
    localparam int PADDR_W         = 3;
    localparam int PDATA_W         = 32;
    localparam int REG_IDX_W       = PADDR_W - 2;

    localparam logic [MODE_W-1:0] MODE_ADD   = MODE_W'(0);
    localparam logic [MODE_W-1:0] MODE_READ  = MODE_W'(1);
    localparam logic [MODE_W-1:0] MODE_CLEAR = MODE_W'(2);

    localparam logic [STATUS_W-1:0] STATUS_OK    = STATUS_W'(0);
    localparam logic [STATUS_W-1:0] STATUS_RANGE = STATUS_W'(1);
    localparam logic [STATUS_W-1:0] STATUS_SAT   = STATUS_W'(2);

    localparam logic [REG_IDX_W-1:0] REG_WIDE_SAMPLES = REG_IDX_W'(0);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_REPLY
    } state_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic clr_en;
        logic clr_reply;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic out_blocked;
    } sts_t;

endpackage

// File: hdl/shist_in_if.sv
// Input channel of the sample histogram: valid/ready plus mode and value.
// Depends on shist_pkg.
interface shist_in_if;
    import shist_pkg::*;

    logic               valid;
    logic               ready;
    logic [MODE_W-1:0]  mode;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output mode, output value, input ready);
    modport sink   (input valid, input mode, input value, output ready);
endinterface

// File: hdl/shist_out_if.sv
// Result channel of the sample histogram: valid/ready plus count and status.
// Depends on shist_pkg.
interface shist_out_if;
    import shist_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [OUT_COUNT_W-1:0] count;
    logic [STATUS_W-1:0]    status;

    modport source (output valid, output count, output status, input ready);
    modport sink   (input valid, input count, input status, output ready);
endinterface

// File: hdl/sample_histogram.sv
// Top level of the sample histogram: register port, controller, datapath.
// Depends on shist_pkg, shist_in_if, shist_out_if, shist_cfg, shist_ctrl, shist_dpath.
//
//   channel  | role          | payload                  | handshake
//   ---------+---------------+--------------------------+-------------------------
//   din      | item in       | mode[1:0], value[15:0]   | valid/ready
//   dout     | result out    | count[31:0], status[1:0] | valid/ready
//   apb      | configuration | wide_samples at byte 0   | psel/penable, pready = 1
//
// An add or read item runs as accept and registered bin read, then update,
// write-back and result load; the single-port bin memory sets this order.
// A clear item is accepted, sweeps all 65536 bins, one per cycle, then
// delivers its result. After reset the same sweep runs over all 65536 bins
// with din held not ready. A stalled dout holds the result; the next item is
// still accepted while a result waits, and execution waits only on a full
// result.
module sample_histogram (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [shist_pkg::PADDR_W-1:0] paddr,
    input  logic [shist_pkg::PDATA_W-1:0] pwdata,
    output logic [shist_pkg::PDATA_W-1:0] prdata,
    output logic                          pready,
    shist_in_if.sink                      din,
    shist_out_if.source                   dout
);
    import shist_pkg::*;

    logic wide;
    cmd_t cmd;
    sts_t sts;

    // Register port: holds the sample-width select.
    shist_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .wide    (wide)
    );

    // Sequencer: reset sweep, item accept, execute, clear sweep and reply.
    shist_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (din.valid),
        .in_mode  (din.mode),
        .in_ready (din.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Bin store, saturating increment and result register.
    shist_dpath u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .wide     (wide),
        .in_mode  (din.mode),
        .in_value (din.value),
        .cmd      (cmd),
        .sts      (sts),
        .dout     (dout)
    );
endmodule

// File: hdl/shist_cfg.sv
// APB-style register file of the sample histogram (wide_samples register).
// Depends on shist_pkg.
module shist_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [shist_pkg::PADDR_W-1:0] paddr,
    input  logic [shist_pkg::PDATA_W-1:0] pwdata,
    output logic [shist_pkg::PDATA_W-1:0] prdata,
    output logic                          pready,
    output logic                          wide
);
    import shist_pkg::*;

    logic                 wide_reg;
    logic                 wide_next;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb
    begin
        wide_next = wide_reg;
        if (wr_en && (reg_idx == REG_WIDE_SAMPLES))
        begin
            wide_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wide_reg <= 1'b0;
        end
        else
        begin
            wide_reg <= wide_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_idx == REG_WIDE_SAMPLES)
        begin
            prdata = {{(PDATA_W-1){1'b0}}, wide_reg};
        end
    end

    assign wide = wide_reg;
endmodule

// File: hdl/shist_dpath.sv
// Datapath of the sample histogram: bin memory, clear sweep, count update
// and result register. Depends on shist_pkg and shist_out_if.
module shist_dpath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wide,
    input  logic [shist_pkg::MODE_W-1:0]  in_mode,
    input  logic [shist_pkg::VALUE_W-1:0] in_value,
    input  shist_pkg::cmd_t               cmd,
    output shist_pkg::sts_t               sts,
    shist_out_if.source                   dout
);
    import shist_pkg::*;

    logic [COUNT_BITS-1:0] mem [2**ADDR_W];

    logic [ADDR_W-1:0]     clr_addr_reg;
    logic [ADDR_W-1:0]     clr_addr_next;
    logic [MODE_W-1:0]     mode_reg;
    logic [ADDR_W-1:0]     addr_reg;
    logic                  oor_reg;
    logic [COUNT_BITS-1:0] rd_data_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [OUT_COUNT_W-1:0] out_count_reg;
    logic [STATUS_W-1:0]   out_status_reg;

    logic [ADDR_W-1:0]     rd_addr;
    logic                  oor;
    logic                  sat;
    logic [COUNT_BITS-1:0] add_cnt;
    logic [COUNT_BITS-1:0] res_count;
    logic [STATUS_W-1:0]   res_status;
    logic [COUNT_BITS+OUT_COUNT_W-1:0] res_ext;
    logic                  load;

    // Bin index: low byte in narrow mode, low ADDR_W bits in wide mode.
    always_comb
    begin
        if (wide)
        begin
            rd_addr = in_value[ADDR_W-1:0];
            oor     = (in_value >> ADDR_W) != '0;
        end
        else
        begin
            rd_addr = ADDR_W'(in_value[NARROW_BITS-1:0]);
            oor     = (in_value >> NARROW_BITS) != '0;
        end
    end

    assign clr_addr_next   = clr_addr_reg + ADDR_W'(1);
    assign sts.clr_last    = (clr_addr_reg == '1);
    assign sts.out_blocked = out_valid_reg && !dout.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.clr_en)
        begin
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg <= in_mode;
            addr_reg <= rd_addr;
            oor_reg  <= oor;
        end
    end

    // Single write port (clear sweep or add write-back), one registered read.
    always_ff @(posedge clk)
    begin
        if (cmd.clr_en)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (cmd.exec && (mode_reg == MODE_ADD))
        begin
            mem[addr_reg] <= add_cnt;
        end
        if (cmd.capture)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign sat     = (rd_data_reg == COUNT_MAX);
    assign add_cnt = sat ? rd_data_reg : rd_data_reg + COUNT_BITS'(1);

    always_comb
    begin
        res_count  = '0;
        res_status = STATUS_OK;
        case (mode_reg)
            MODE_ADD:
            begin
                res_count  = add_cnt;
                res_status = sat ? STATUS_SAT : STATUS_OK;
            end
            MODE_READ:
            begin
                if (oor_reg)
                begin
                    res_status = STATUS_RANGE;
                end
                else
                begin
                    res_count = rd_data_reg;
                end
            end
            default:
            begin
                res_count  = '0;
                res_status = STATUS_OK;
            end
        endcase
    end

    assign res_ext = {{OUT_COUNT_W{1'b0}}, res_count};
    assign load    = cmd.exec || cmd.clr_reply;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (dout.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            out_count_reg  <= res_ext[OUT_COUNT_W-1:0];
            out_status_reg <= res_status;
        end
        else if (cmd.clr_reply)
        begin
            out_count_reg  <= '0;
            out_status_reg <= STATUS_OK;
        end
    end

    assign dout.valid  = out_valid_reg;
    assign dout.count  = out_count_reg;
    assign dout.status = out_status_reg;
endmodule

// File: hdl/shist_ctrl.sv
// Controller of the sample histogram: sequences clear sweeps, item fetch
// and execution. Depends on shist_pkg.
module shist_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic [shist_pkg::MODE_W-1:0] in_mode,
    output logic                         in_ready,
    input  shist_pkg::sts_t              sts,
    output shist_pkg::cmd_t              cmd
);
    import shist_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   reply_reg;
    logic   reply_next;
    logic   capture;

    assign in_ready = (state_reg == ST_IDLE);
    assign capture  = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        reply_next = reply_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (sts.clr_last)
                begin
                    state_next = reply_reg ? ST_REPLY : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (capture)
                begin
                    if (in_mode == MODE_CLEAR)
                    begin
                        state_next = ST_CLEAR;
                        reply_next = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_EXEC;
                    end
                end
            end
            ST_EXEC:
            begin
                if (!sts.out_blocked)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_REPLY:
            begin
                if (!sts.out_blocked)
                begin
                    state_next = ST_IDLE;
                    reply_next = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd.capture   = capture;
        cmd.exec      = (state_reg == ST_EXEC) && !sts.out_blocked;
        cmd.clr_en    = (state_reg == ST_CLEAR);
        cmd.clr_reply = (state_reg == ST_REPLY) && !sts.out_blocked;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            reply_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            reply_reg <= reply_next;
        end
    end

`ifndef SYNTHESIS
    // A clear item starts a sweep in the very next cycle.
    a_clear_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (capture && (in_mode == MODE_CLEAR)) |=> (state_reg == ST_CLEAR))
        else $error("clear item did not start a sweep");

    // The memory write port never sees a sweep write and a write-back together.
    a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.exec && cmd.clr_en))
        else $error("sweep and write-back collide");

    // The sweep ends after the last bin.
    a_sweep_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.clr_en && sts.clr_last) |=> (state_reg != ST_CLEAR))
        else $error("sweep did not end at the last bin");

    // A result is never loaded over one that is still waiting.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec || cmd.clr_reply) |-> !sts.out_blocked)
        else $error("result register overwritten");
`endif
endmodule
